FILE: rtl/core/text_line_justifier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text line justifier
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_JUSTIFIER_MACROS_SVH
`define TEXT_LINE_JUSTIFIER_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge while reset is released.
`define TLJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising clock edge, reset included.
`define TLJ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TLJ_ASSERT(lbl, prop, msg)
`define TLJ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/tlj_pkg.sv
// ----------------------------------------------------------------------------
// Text line justifier package
// Sizes, character codes and shared types of the justifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tlj_pkg;

  localparam int unsigned LINE_CHARS  = 79;
  localparam int unsigned MAX_WORDS   = 40;
  localparam int unsigned CHUNK_BYTES = 8;
  localparam int unsigned OUT_LIMIT   = 79;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CNT_W       = $clog2(LINE_CHARS + 1);
  localparam int unsigned ADDR_W      = $clog2(LINE_CHARS);
  localparam int unsigned WORD_W      = $clog2(MAX_WORDS + 1);
  localparam int unsigned OLEN_W      = $clog2(OUT_LIMIT + 1);
  localparam int unsigned LWID_W      = 7;
  localparam int unsigned CCNT_W      = 4;
  localparam int unsigned CIDX_W      = $clog2(CHUNK_BYTES);
  localparam int unsigned CHARS_W     = 64;
  localparam int unsigned DIV_W       = LWID_W;
  localparam int unsigned DSTEP_W     = $clog2(DIV_W + 1);

  localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'h20;
  localparam logic [LWID_W-1:0] LINE_WIDTH_RST = 7'd79;

  // Status of the gap divider as seen by the sequencer.
  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [DIV_W-1:0]  rem;
  } div_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/tlj_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tlj_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tlj_div.sv
// ----------------------------------------------------------------------------
// Gap divider
// Restoring divider, one quotient bit per cycle, for the space split.
// ----------------------------------------------------------------------------
`default_nettype none

module tlj_div import tlj_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_W-1:0]  dividend_i,
  input  wire logic [WORD_W-1:0] divisor_i,
  output div_res_t               res_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DSTEP_W-1:0] step_q, step_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [DIV_W:0]    shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, quo_q[DIV_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = DSTEP_W'(DIV_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = DIV_W'(divisor_i);
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = DIV_W'(shifted - {1'b0, dvs_q});
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == DSTEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/core/text_line_justifier.sv
// ----------------------------------------------------------------------------
// Text line justifier
// Stores one text line and streams it back in 8-byte chunks, justified if due.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata: char_code; tuser: char_valid, paragraph_last;
//                       tlast: line_end
//  m_axis    out        tdata: out_chars, out_count; tlast: out_last
//  cfg       in         data: line_width (always ready)
//
// A request loads one character per cycle while loading. After the line end
// it picks the alignment, divides the gap if justifying, streams the
// characters and gaps and closes the line. One-word, full and paragraph-end
// lines are not justified. No request is taken until the last chunk is
// loaded. A full chunk facing a stalled output register holds the sequencer.
// Reset clears all control state; the line store itself needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_line_justifier_macros.svh"

module text_line_justifier import tlj_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [7:0]        s_axis_tdata_i,   // [7:0] char_code
  input  wire logic [1:0]        s_axis_tuser_i,   // [0] char_valid, [1] paragraph_last
  input  wire logic              s_axis_tlast_i,   // line_end
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic      [71:0]       m_axis_tdata_o,   // [63:0] out_chars, [67:64] out_count
  output logic                   m_axis_tlast_o,   // out_last
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [LWID_W-1:0] cfg_data_i        // line_width
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_CHAR  = 3'd4;
  localparam logic [2:0] S_SPACE = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [LWID_W-1:0]   line_width_q;
  logic [CNT_W-1:0]    char_count_q, char_count_d;
  logic [WORD_W-1:0]   word_count_q, word_count_d;
  logic [CNT_W-1:0]    content_q, content_d;
  logic                inside_q, inside_d;
  logic                para_q, para_d;
  logic                justify_q, justify_d;
  logic [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic [WORD_W-1:0]   widx_q, widx_d;
  logic                in_word_q, in_word_d;
  logic [LWID_W-1:0]   sp_left_q, sp_left_d;
  logic [OLEN_W-1:0]   olen_q, olen_d;
  logic [CHARS_W-1:0]  chunk_q, chunk_d;
  logic [CCNT_W-1:0]   chunk_cnt_q, chunk_cnt_d;

  logic                out_valid_q;
  logic [CHARS_W-1:0]  out_chars_q;
  logic [CCNT_W-1:0]   out_cnt_q;
  logic                out_last_q;
  logic                out_free;
  logic                out_load;
  logic                out_load_last;

  logic                ram_we, ram_re;
  logic [CHAR_W-1:0]   ram_rdata;
  logic                div_start;
  div_res_t            div_res;

  logic                in_acc;
  logic                emit_req, emit_ok, emit_push;
  logic [CHAR_W-1:0]   emit_byte;
  logic                justify_now;
  logic [LWID_W-1:0]   gap_spaces;
  logic                extra_gap;

  assign in_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o = 1'b1;

  assign justify_now = !((word_count_q <= WORD_W'(1)) || para_q ||
                         (content_q >= CNT_W'(line_width_q)));
  assign extra_gap   = DIV_W'(widx_q - 1'b1) < div_res.rem;
  assign gap_spaces  = justify_q ? LWID_W'(div_res.quot + DIV_W'(extra_gap))
                                 : LWID_W'(1);

  // A byte may be placed unless the chunk is full and cannot move out.
  assign emit_ok   = (olen_q >= OLEN_W'(OUT_LIMIT)) ||
                     (chunk_cnt_q != CCNT_W'(CHUNK_BYTES)) || out_free;
  assign emit_push = emit_req && emit_ok && (olen_q < OLEN_W'(OUT_LIMIT));

  tlj_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_CHARS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ADDR_W'(char_count_q)),
    .wdata_i (s_axis_tdata_i),
    .re_i    (ram_re),
    .raddr_i (ADDR_W'(rd_idx_q)),
    .rdata_o (ram_rdata)
  );

  tlj_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_W'(line_width_q) - DIV_W'(content_q)),
    .divisor_i  (word_count_q - 1'b1),
    .res_o      (div_res)
  );

  always_comb begin
    state_d       = state_q;
    char_count_d  = char_count_q;
    word_count_d  = word_count_q;
    content_d     = content_q;
    inside_d      = inside_q;
    para_d        = para_q;
    justify_d     = justify_q;
    rd_idx_d      = rd_idx_q;
    widx_d        = widx_q;
    in_word_d     = in_word_q;
    sp_left_d     = sp_left_q;
    olen_d        = olen_q;
    chunk_d       = chunk_q;
    chunk_cnt_d   = chunk_cnt_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_load_last = 1'b0;
    emit_req      = 1'b0;
    emit_byte     = ram_rdata;
    s_axis_tready_o = (state_q == S_LOAD);

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (s_axis_tuser_i[0] && (char_count_q < CNT_W'(LINE_CHARS))) begin
            ram_we       = 1'b1;
            char_count_d = char_count_q + 1'b1;
            if (s_axis_tdata_i == SPACE_CODE) begin
              inside_d = 1'b0;
            end else if (inside_q) begin
              content_d = content_q + 1'b1;
            end else if (word_count_q < WORD_W'(MAX_WORDS)) begin
              word_count_d = word_count_q + 1'b1;
              content_d    = content_q + 1'b1;
              inside_d     = 1'b1;
            end
          end
          if (s_axis_tlast_i) begin
            para_d  = s_axis_tuser_i[1];
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        justify_d   = justify_now;
        rd_idx_d    = '0;
        widx_d      = '0;
        in_word_d   = 1'b0;
        olen_d      = '0;
        chunk_d     = '0;
        chunk_cnt_d = '0;
        if (justify_now) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        if (rd_idx_q == char_count_q) begin
          state_d = S_FLUSH;
        end else begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
          state_d  = S_CHAR;
        end
      end
      S_CHAR: begin
        if (ram_rdata == SPACE_CODE) begin
          in_word_d = 1'b0;
          state_d   = S_FETCH;
        end else if (in_word_q) begin
          emit_req = 1'b1;
          if (emit_ok) begin
            state_d = S_FETCH;
          end
        end else if (widx_q >= word_count_q) begin
          // Words past the word limit end the line.
          state_d = S_FLUSH;
        end else if (widx_q != '0) begin
          sp_left_d = gap_spaces;
          widx_d    = widx_q + 1'b1;
          in_word_d = 1'b1;
          state_d   = S_SPACE;
        end else begin
          emit_req = 1'b1;
          if (emit_ok) begin
            widx_d    = widx_q + 1'b1;
            in_word_d = 1'b1;
            state_d   = S_FETCH;
          end
        end
      end
      S_SPACE: begin
        // The read data still holds the first character of the next word.
        if ((sp_left_q != '0) && (olen_q < OLEN_W'(OUT_LIMIT))) begin
          emit_req  = 1'b1;
          emit_byte = SPACE_CODE;
          if (emit_ok) begin
            sp_left_d = sp_left_q - 1'b1;
          end
        end else begin
          emit_req = 1'b1;
          if (emit_ok) begin
            state_d = S_FETCH;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
          char_count_d  = '0;
          word_count_d  = '0;
          content_d     = '0;
          inside_d      = 1'b0;
          state_d       = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    // A full chunk leaves only when the next byte arrives, so the final
    // chunk of a line always goes out with the last flag set.
    if (emit_push) begin
      olen_d = olen_q + 1'b1;
      if (chunk_cnt_q == CCNT_W'(CHUNK_BYTES)) begin
        out_load                 = 1'b1;
        chunk_d                  = '0;
        chunk_d[CHAR_W-1:0]      = emit_byte;
        chunk_cnt_d              = CCNT_W'(1);
      end else begin
        chunk_d[CHAR_W*chunk_cnt_q[CIDX_W-1:0] +: CHAR_W] = emit_byte;
        chunk_cnt_d = chunk_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      line_width_q <= LINE_WIDTH_RST;
      char_count_q <= '0;
      word_count_q <= '0;
      content_q    <= '0;
      inside_q     <= 1'b0;
      para_q       <= 1'b0;
      justify_q    <= 1'b0;
      rd_idx_q     <= '0;
      widx_q       <= '0;
      in_word_q    <= 1'b0;
      sp_left_q    <= '0;
      olen_q       <= '0;
      chunk_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        line_width_q <= cfg_data_i;
      end
      char_count_q <= char_count_d;
      word_count_q <= word_count_d;
      content_q    <= content_d;
      inside_q     <= inside_d;
      para_q       <= para_d;
      justify_q    <= justify_d;
      rd_idx_q     <= rd_idx_d;
      widx_q       <= widx_d;
      in_word_q    <= in_word_d;
      sp_left_q    <= sp_left_d;
      olen_q       <= olen_d;
      chunk_cnt_q  <= chunk_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chunk_q <= chunk_d;
    if (out_load) begin
      out_chars_q <= chunk_q;
      out_cnt_q   <= chunk_cnt_q;
      out_last_q  <= out_load_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_cnt_q, out_chars_q};
  assign m_axis_tlast_o  = out_last_q;

  `TLJ_ASSERT(a_short_chunk_is_last,
              (m_axis_tvalid_o && (out_cnt_q != CCNT_W'(CHUNK_BYTES))) |-> out_last_q,
              "partial chunk sent without the last flag")
  `TLJ_ASSERT_ALWAYS(a_olen_limit, olen_q <= OLEN_W'(OUT_LIMIT),
                     "justified line exceeds the output limit")
  `TLJ_ASSERT(a_div_done_in_wait, div_res.done |-> (state_q == S_DIV),
              "divider finished outside its wait state")
  `TLJ_ASSERT_ALWAYS(a_counts_consistent,
                     (char_count_q <= CNT_W'(LINE_CHARS)) && (content_q <= char_count_q),
                     "line counters out of range")

endmodule

`default_nettype wire
